// File: hw/rtl/fragment_retransmit_tracker_macros.svh
// ----------------------------------------------------------------------------
// Fragment retransmit tracker assertion macros
// Concurrent assertion wrappers on clk with synchronous reset rst; empty
// bodies when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FRAGMENT_RETRANSMIT_TRACKER_MACROS_SVH
`define FRAGMENT_RETRANSMIT_TRACKER_MACROS_SVH
`ifndef SYNTHESIS
`define FRT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FRT_ASSERT(label, prop, msg)
`define FRT_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: hw/rtl/frt_pkg.sv
// ----------------------------------------------------------------------------
// Fragment retransmit tracker package
// Field widths, operation codes, register indexes and transaction types.
// ----------------------------------------------------------------------------
package frt_pkg;

  localparam int KIND_W     = 2;
  localparam int SIZE_W     = 12;
  localparam int ID_W       = 16;
  localparam int NUM_W      = 5;
  localparam int OFF_W      = 11;
  localparam int TIME_W     = 32;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int MAX_OUT    = 32;
  localparam int EMIT_W     = $clog2(MAX_OUT);

  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ACK   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SEND  = 2'd3;

  localparam logic REG_FRAG_LIMIT = 1'b0;
  localparam logic REG_TIMEOUT    = 1'b1;

  localparam logic [SIZE_W-1:0] FRAG_LIMIT_RST = 12'd560;
  localparam logic [TIME_W-1:0] TIMEOUT_RST    = 32'd5000;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SIZE_W-1:0] msg_len;
    logic [ID_W-1:0]   frag_id;
  } item_t;

  typedef struct packed {
    logic              has_fragment;
    logic [NUM_W-1:0]  frag_number;
    logic [OFF_W-1:0]  byte_offset;
    logic [SIZE_W-1:0] frag_bytes;
    logic              last;
    logic              busy_res;
    logic              rejected;
  } result_t;

endpackage

// File: hw/rtl/frt_cfg.sv
// ----------------------------------------------------------------------------
// Fragment retransmit tracker configuration registers
// APB-style register file holding the fragment limit and the resend limit.
// ----------------------------------------------------------------------------
module frt_cfg import frt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [SIZE_W-1:0]     frag_limit,
  output logic [TIME_W-1:0]     resend_limit
);

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      frag_limit   <= FRAG_LIMIT_RST;
      resend_limit <= TIMEOUT_RST;
    end else if (wr_en) begin
      if (reg_sel == REG_TIMEOUT) begin
        resend_limit <= pwdata[TIME_W-1:0];
      end else begin
        frag_limit <= pwdata[SIZE_W-1:0];
      end
    end
  end

  always_comb begin
    if (reg_sel == REG_TIMEOUT) begin
      prdata = resend_limit;
    end else begin
      prdata = {(APB_DATA_W - SIZE_W)'(0), frag_limit};
    end
  end

endmodule

// File: hw/rtl/frt_size_mem.sv
// ----------------------------------------------------------------------------
// Fragment size memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module frt_size_mem #(
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5,
  parameter int DATA_W = 12
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold the last read word while the reader stalls.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/fragment_retransmit_tracker.sv
// ----------------------------------------------------------------------------
// Fragment retransmit tracker
// Transmit-side bookkeeping of a selective-repeat fragmenting sender.
// ----------------------------------------------------------------------------
// One input transaction is taken at a time. A start writes the fragment
// sizes of its message into the size memory one entry per cycle through
// its single write port, then gives its result. A send pass or a
// resending tick walks the size memory one entry per cycle through its
// read port, which has registered read data, while the result side does
// not stall. Acks, idle passes, rejected starts and ticks without resend
// go straight to their single result. Each transaction gives one or more
// result transactions; the last of them has last set, and the next input
// is taken as soon as that last result sits in the output register, even
// if it has not been taken yet.
// ----------------------------------------------------------------------------
module fragment_retransmit_tracker import frt_pkg::*; #(
  parameter int FRAG_SLOTS   = 32,
  parameter int BUFFER_BYTES = 2048
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output result_t               result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

`include "fragment_retransmit_tracker_macros.svh"

  localparam int IDX_W = (FRAG_SLOTS > 1) ? $clog2(FRAG_SLOTS) : 1;
  localparam int TOT_W = $clog2(FRAG_SLOTS + 1);
  localparam int CAP_W = SIZE_W + TOT_W;
  localparam int BUF_W = 17;
  localparam logic [TOT_W-1:0] SLOTS_T = TOT_W'(FRAG_SLOTS);
  localparam logic [BUF_W-1:0] BUF_LIM = BUF_W'(BUFFER_BYTES);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_FILL   = 2'd1;
  localparam logic [1:0] ST_WALK   = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  // Configuration
  logic [SIZE_W-1:0] frag_limit;
  logic [TIME_W-1:0] resend_limit;

  // Transfer state
  logic [1:0]            state;
  logic                  active;
  logic [TOT_W-1:0]      frag_total;
  logic [FRAG_SLOTS-1:0] acked;
  logic [TIME_W-1:0]     elapsed;

  // Fill sequencer
  logic [SIZE_W-1:0] rest;
  logic [TOT_W-1:0]  widx;
  logic [SIZE_W-1:0] chunk;
  logic              mem_wr_en;

  // Walk sequencer: read issue and data stage
  logic [TOT_W-1:0]  ridx;
  logic              b_valid;
  logic [IDX_W-1:0]  b_idx;
  logic [SIZE_W-1:0] off;
  logic [EMIT_W-1:0] n_emit;
  logic [SIZE_W-1:0] rd_data;
  logic              rd_en;

  // Pending result flags of the current transaction
  logic res_rej;
  logic res_busy;

  // Derived control
  logic                  item_acc;
  logic                  out_free;
  logic                  res_load;
  logic [FRAG_SLOTS-1:0] pend_vec;
  logic [FRAG_SLOTS-1:0] above;
  logic                  any_pend;
  logic                  hi_pend;
  logic                  b_pend;
  logic                  b_last;
  logic                  b_go;
  logic                  advance;
  logic                  walk_done;
  logic [TIME_W-1:0]     elapsed_inc;
  logic                  timed_out;
  logic [CAP_W-1:0]      cap;
  logic                  too_big;
  logic                  id_ok;

  frt_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .frag_limit   (frag_limit),
    .resend_limit (resend_limit)
  );

  // Fill and walk never overlap, so the same entry is never written and
  // read in one cycle and the memory needs no forwarding.
  frt_size_mem #(
    .DEPTH  (FRAG_SLOTS),
    .ADDR_W (IDX_W),
    .DATA_W (SIZE_W)
  ) u_size_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (widx[IDX_W-1:0]),
    .wr_data (chunk),
    .rd_en   (rd_en),
    .rd_addr (ridx[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  assign item_ready = (state == ST_IDLE);
  assign item_acc   = item_valid & item_ready;
  assign out_free   = !result_valid || result_ready;

  // A slot is pending when it is part of the message and not yet acked.
  always_comb begin
    for (int j = 0; j < FRAG_SLOTS; j++) begin
      pend_vec[j] = !acked[j] && (TOT_W'(j) < frag_total);
      above[j]    = (IDX_W'(j) > b_idx);
    end
  end

  assign any_pend = |pend_vec;
  assign hi_pend  = |(pend_vec & above);

  // The timer runs as elapsed ticks since the last restart; wraps mod 2^32.
  assign elapsed_inc = elapsed + TIME_W'(1);
  assign timed_out   = elapsed_inc > resend_limit;

  // Message needs more slots than exist exactly when it exceeds
  // the fragment limit times the slot count.
  assign cap     = {TOT_W'(0), frag_limit} * {SIZE_W'(0), SLOTS_T};
  assign too_big = (frag_limit == '0)
                || ({(BUF_W - SIZE_W)'(0), item.msg_len} > BUF_LIM)
                || ({TOT_W'(0), item.msg_len} > cap);
  assign id_ok   = item.frag_id < ID_W'(frag_total);

  assign chunk     = (rest > frag_limit) ? frag_limit : rest;
  assign mem_wr_en = (state == ST_FILL) && (rest != '0);

  // Walk data stage: emit the slot if pending, always add its size to the
  // running offset. The last emission ends the pass; cap at MAX_OUT results.
  assign b_pend    = pend_vec[b_idx];
  assign b_last    = !hi_pend || (n_emit == EMIT_W'(MAX_OUT - 1));
  assign b_go      = b_valid && (!b_pend || out_free);
  assign advance   = !b_valid || b_go;
  assign walk_done = b_go && b_pend && b_last;
  assign rd_en     = (state == ST_WALK) && advance && (ridx < frag_total) && !walk_done;

  // A new result enters the output register this cycle.
  assign res_load = ((state == ST_WALK) && b_go && b_pend)
                 || ((state == ST_RESULT) && out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      active       <= 1'b0;
      frag_total   <= '0;
      acked        <= '0;
      elapsed      <= '0;
      result_valid <= 1'b0;
      b_valid      <= 1'b0;
    end else begin
      // Drop the output once it has been taken, unless a new one loads.
      if (result_valid && result_ready && !res_load) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (item_acc) begin
            res_rej <= (item.kind == KIND_START) && too_big;
            case (item.kind)
              KIND_START: begin
                if (too_big) begin
                  // Refuse and leave the ongoing transfer untouched.
                  res_busy <= active;
                  state    <= ST_RESULT;
                end else begin
                  acked    <= '0;
                  active   <= 1'b1;
                  elapsed  <= '0;
                  rest     <= item.msg_len;
                  widx     <= '0;
                  res_busy <= 1'b1;
                  state    <= ST_FILL;
                end
              end
              KIND_TICK: begin
                if (active) begin
                  active   <= any_pend;
                  res_busy <= any_pend;
                  if (timed_out) begin
                    elapsed <= '0;
                  end else begin
                    elapsed <= elapsed_inc;
                  end
                  if (timed_out && any_pend) begin
                    ridx    <= '0;
                    off     <= '0;
                    n_emit  <= '0;
                    b_valid <= 1'b0;
                    state   <= ST_WALK;
                  end else begin
                    state <= ST_RESULT;
                  end
                end else begin
                  // Idle sender: only advance time.
                  elapsed  <= elapsed_inc;
                  res_busy <= 1'b0;
                  state    <= ST_RESULT;
                end
              end
              KIND_ACK: begin
                // Acks outside the message are ignored, even while idle.
                if (id_ok) begin
                  acked[item.frag_id[IDX_W-1:0]] <= 1'b1;
                end
                res_busy <= active;
                state    <= ST_RESULT;
              end
              KIND_SEND: begin
                res_busy <= active;
                if (active && any_pend) begin
                  ridx    <= '0;
                  off     <= '0;
                  n_emit  <= '0;
                  b_valid <= 1'b0;
                  state   <= ST_WALK;
                end else begin
                  state <= ST_RESULT;
                end
              end
              default: begin
                state <= ST_RESULT;
              end
            endcase
          end
        end
        ST_FILL: begin
          // Cut one fragment per cycle; the count of cuts is the total.
          if (rest == '0) begin
            frag_total <= widx;
            state      <= ST_RESULT;
          end else begin
            rest <= rest - chunk;
            widx <= widx + TOT_W'(1);
          end
        end
        ST_WALK: begin
          if (rd_en) begin
            ridx    <= ridx + TOT_W'(1);
            b_valid <= 1'b1;
            b_idx   <= ridx[IDX_W-1:0];
          end else if (b_go) begin
            b_valid <= 1'b0;
          end
          if (b_go) begin
            off <= off + rd_data;
            if (b_pend) begin
              result_valid        <= 1'b1;
              result.has_fragment <= 1'b1;
              result.frag_number  <= NUM_W'(b_idx);
              result.byte_offset  <= off[OFF_W-1:0];
              result.frag_bytes   <= rd_data;
              result.last         <= b_last;
              result.busy_res     <= res_busy;
              result.rejected     <= 1'b0;
              n_emit              <= n_emit + EMIT_W'(1);
            end
          end
          if (walk_done) begin
            state <= ST_IDLE;
          end
        end
        ST_RESULT: begin
          // Single result with no fragment: hold until the output frees.
          if (out_free) begin
            result_valid        <= 1'b1;
            result.has_fragment <= 1'b0;
            result.frag_number  <= '0;
            result.byte_offset  <= '0;
            result.frag_bytes   <= '0;
            result.last         <= 1'b1;
            result.busy_res     <= res_busy;
            result.rejected     <= res_rej;
            state               <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Every accepted transaction takes the sequencer out of idle, so ready drops.
  `FRT_ASSERT_NEXT(a_accept_leaves_idle, item_valid && item_ready, !item_ready, "input taken twice in a row")
  // A result without a fragment is always the only result of its transaction.
  `FRT_ASSERT(a_null_result_last, (result_valid && !result.has_fragment) |-> result.last, "empty result without last")
  // A refused start never carries a fragment.
  `FRT_ASSERT(a_reject_no_frag, (result_valid && result.rejected) |-> !result.has_fragment, "rejected result carries fragment")
  // The fill never writes past the slot count.
  `FRT_ASSERT(a_fill_in_range, (state == ST_FILL && rest != '0) |-> (widx < SLOTS_T), "fill beyond fragment slots")
  // Emitted fragments are never empty.
  `FRT_ASSERT(a_frag_nonempty, (result_valid && result.has_fragment) |-> (result.frag_bytes != '0), "empty fragment emitted")

endmodule

// File: bench/fragment_retransmit_tracker_tb.sv
// ----------------------------------------------------------------------------
// Fragment retransmit tracker testbench
// Drives start, tick, ack and send-pass transactions into the tracker and
// predicts every fragment it should emit. The prediction tracks fragment
// sizes, the ack map, the busy flag and the retransmit timer. Each result
// transaction is compared field by field in order. Directed tests cover the
// register extremes, rejected starts, empty messages, replaced transfers,
// out-of-range acks and timer-driven resends. A long receiver hold-off fills
// the block. Random phases with sender gaps and receiver stalls follow.
// ----------------------------------------------------------------------------
module fragment_retransmit_tracker_tb;
  import frt_pkg::*;

  localparam int FRAG_SLOTS    = 32;
  localparam int BUFFER_BYTES  = 2048;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;

  // Clock, reset and block ports; every input starts at a known value.
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_ready;
  item_t                 item = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  result_t               result;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Traffic shaping knobs, set by the tests.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  logic        hold_go = 1'b0;
  int unsigned hold_left = 0;

  // Predicted tracker state and register copies.
  logic [SIZE_W-1:0] payload_cfg = FRAG_LIMIT_RST;
  logic [TIME_W-1:0] timeout_cfg = TIMEOUT_RST;
  logic [SIZE_W-1:0] frag_len [FRAG_SLOTS];
  logic [31:0]       acked_mask = '0;
  int unsigned       frag_count = 0;
  logic              sending = 1'b0;
  logic [TIME_W-1:0] now_ticks = '0;
  logic [TIME_W-1:0] armed_at = '0;

  // Results expected from the block, oldest first.
  result_t due_results[$];
  result_t step_out[$];

  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;

  fragment_retransmit_tracker #(
    .FRAG_SLOTS  (FRAG_SLOTS),
    .BUFFER_BYTES(BUFFER_BYTES)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("fragment_retransmit_tracker_tb failed");
      $finish;
    end
  end

  // Receiver: stall at random, or hold off entirely for a counted stretch.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_go) begin
      result_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      result_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      result_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                results_seen, name, got, want));
  endtask

  // Compare every accepted result transaction against the oldest prediction.
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", result));
      end else begin
        want = due_results.pop_front();
        check_field("has_fragment", 32'(result.has_fragment), 32'(want.has_fragment));
        check_field("frag_number", 32'(result.frag_number), 32'(want.frag_number));
        check_field("byte_offset", 32'(result.byte_offset), 32'(want.byte_offset));
        check_field("frag_bytes", 32'(result.frag_bytes), 32'(want.frag_bytes));
        check_field("last", 32'(result.last), 32'(want.last));
        check_field("busy_res", 32'(result.busy_res), 32'(want.busy_res));
        check_field("rejected", 32'(result.rejected), 32'(want.rejected));
      end
      results_seen++;
    end
  end

  // Queue every unacknowledged fragment; offsets count acked slots too.
  task automatic queue_unacked();
    result_t r;
    int unsigned offs;
    int i;
    offs = 0;
    for (i = 0; i < frag_count; i++) begin
      if (!acked_mask[i]) begin
        r = '0;
        r.has_fragment = 1'b1;
        r.frag_number = NUM_W'(i);
        r.byte_offset = OFF_W'(offs);
        r.frag_bytes = frag_len[i];
        step_out.push_back(r);
      end
      offs += 32'(frag_len[i]);
    end
  endtask

  // Advance the predicted tracker by one accepted transaction and queue
  // the results it should produce.
  task automatic track_item(input item_t it);
    result_t r;
    int unsigned size, mp, count, rest, chunk;
    logic rej;
    logic done;
    int i;
    rej = 1'b0;
    step_out.delete();
    size = 32'(it.msg_len);
    mp = 32'(payload_cfg);
    case (it.kind)
      KIND_START: begin
        if (mp == 0 || size > BUFFER_BYTES) begin
          rej = 1'b1;
        end else begin
          count = (size + mp - 1) / mp;
          if (count > FRAG_SLOTS) begin
            rej = 1'b1;
          end else begin
            rest = size;
            for (i = 0; i < count; i++) begin
              chunk = (rest > mp) ? mp : rest;
              frag_len[i] = SIZE_W'(chunk);
              rest -= chunk;
            end
            acked_mask = '0;
            frag_count = count;
            sending = 1'b1;
            armed_at = now_ticks;
          end
        end
      end
      KIND_TICK: begin
        now_ticks = now_ticks + 1;
        if (sending) begin
          // Wrapping elapsed time; resend only when strictly past the limit.
          if (TIME_W'(now_ticks - armed_at) > timeout_cfg) begin
            armed_at = now_ticks;
            queue_unacked();
          end
          done = 1'b1;
          for (i = 0; i < frag_count; i++)
            if (!acked_mask[i]) done = 1'b0;
          if (done) sending = 1'b0;
        end
      end
      KIND_ACK: begin
        // Drop acks past the fragment total; apply the rest even when idle.
        if (it.frag_id < frag_count) acked_mask[it.frag_id[NUM_W-1:0]] = 1'b1;
      end
      KIND_SEND: begin
        if (sending) queue_unacked();
      end
      default: ;
    endcase
    if (step_out.size() == 0) begin
      r = '0;
      r.rejected = rej;
      step_out.push_back(r);
    end
    for (i = 0; i < step_out.size(); i++) begin
      r = step_out[i];
      r.busy_res = sending;
      r.last = (i == step_out.size() - 1);
      due_results.push_back(r);
    end
  endtask

  // Offer one transaction, with a random gap first, and hold it until taken.
  // Valid stays high afterwards so the next call can follow back to back.
  task automatic send_item(input item_t it);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    track_item(it);
  endtask

  function automatic item_t make_item(input logic [KIND_W-1:0] kind,
                                      input int unsigned size,
                                      input int unsigned id);
    item_t it;
    it.kind = kind;
    it.msg_len = SIZE_W'(size);
    it.frag_id = ID_W'(id);
    return it;
  endfunction

  task automatic send_op(input logic [KIND_W-1:0] kind, input int unsigned size,
                         input int unsigned id);
    send_item(make_item(kind, size, id));
  endtask

  // Drop valid and let every expected result drain before touching registers.
  task automatic wait_idle();
    item_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One APB transfer: setup cycle, then access until pready.
  task automatic apb_access(input logic wr, input logic idx,
                            input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_reg(input logic idx, input logic [APB_DATA_W-1:0] want);
    logic [APB_DATA_W-1:0] got;
    apb_access(1'b0, idx, '0, got);
    if (got != want)
      report_mismatch($sformatf("register %0d reads %h, expected %h", idx, got, want));
  endtask

  task automatic set_config(input logic [SIZE_W-1:0] mp, input logic [TIME_W-1:0] to);
    logic [APB_DATA_W-1:0] unused;
    apb_access(1'b1, REG_FRAG_LIMIT, APB_DATA_W'(mp), unused);
    apb_access(1'b1, REG_TIMEOUT, to, unused);
    payload_cfg = mp;
    timeout_cfg = to;
    check_reg(REG_FRAG_LIMIT, APB_DATA_W'(mp));
    check_reg(REG_TIMEOUT, to);
  endtask

  task automatic test_reset_values();
    check_reg(REG_FRAG_LIMIT, APB_DATA_W'(FRAG_LIMIT_RST));
    check_reg(REG_TIMEOUT, TIMEOUT_RST);
  endtask

  // Reset settings: 560-byte fragments, timer far away.
  task automatic test_basic_transfer();
    send_op(KIND_START, 0, 0);        // empty message goes busy
    send_op(KIND_TICK, 0, 0);         // and the next tick finishes it
    send_op(KIND_SEND, 0, 0);         // idle pass emits nothing
    send_op(KIND_START, 4095, 0);     // over the buffer: refused
    send_op(KIND_START, 2048, 0);     // four fragments, short remainder
    send_op(KIND_SEND, 0, 0);
    send_op(KIND_ACK, 0, 1);
    send_op(KIND_ACK, 0, 4);          // one past the total: ignored
    send_op(KIND_ACK, 4095, 65535);
    send_op(KIND_SEND, 0, 0);         // gap in the offsets where slot 1 was
    send_op(KIND_TICK, 0, 0);
    send_op(KIND_START, 1000, 0);     // replaces the running transfer
    send_op(KIND_ACK, 0, 0);
    send_op(KIND_ACK, 0, 1);
    send_op(KIND_SEND, 0, 0);         // all acked but still busy until a tick
    send_op(KIND_TICK, 0, 0);
    send_op(KIND_ACK, 0, 0);          // ack while idle still lands in the map
    send_op(KIND_SEND, 0, 0);
  endtask

  task automatic test_payload_extremes();
    wait_idle();
    set_config(12'd1, TIMEOUT_RST);
    send_op(KIND_START, 32, 0);       // every slot in use
    send_op(KIND_SEND, 0, 0);
    send_op(KIND_START, 33, 0);       // one fragment too many
    wait_idle();
    set_config(12'd0, TIMEOUT_RST);
    send_op(KIND_START, 0, 0);        // zero payload refuses everything
    send_op(KIND_START, 5, 0);
    wait_idle();
    set_config(12'd2048, 32'hFFFF_FFFF);
    send_op(KIND_START, 2049, 0);
    send_op(KIND_START, 2048, 0);
    send_op(KIND_TICK, 0, 0);         // timer at its maximum never fires
    wait_idle();
    set_config(12'd4095, 32'hFFFF_FFFF);
    send_op(KIND_START, 2048, 0);
    send_op(KIND_SEND, 0, 0);
  endtask

  task automatic test_timeout_resend();
    wait_idle();
    set_config(12'd500, 32'd0);       // every tick is past the limit
    send_op(KIND_START, 1500, 0);
    send_op(KIND_TICK, 0, 0);
    send_op(KIND_ACK, 0, 1);
    send_op(KIND_TICK, 0, 0);
    send_op(KIND_ACK, 0, 0);
    send_op(KIND_ACK, 0, 2);
    send_op(KIND_TICK, 0, 0);         // nothing left: resend is empty, goes idle
    wait_idle();
    set_config(12'd500, 32'd2);
    send_op(KIND_START, 700, 0);
    send_op(KIND_TICK, 0, 0);
    send_op(KIND_TICK, 0, 0);
    send_op(KIND_TICK, 0, 0);         // third tick exceeds the limit
  endtask

  // Block the result side while the sender keeps offering full passes.
  task automatic test_backpressure();
    int i;
    wait_idle();
    send_idle_pct = 0;
    stall_pct = 0;
    set_config(12'd64, 32'hFFFF_FFFF);
    send_op(KIND_START, 2048, 0);
    @(posedge clk);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    for (i = 0; i < 5; i++) send_op(KIND_SEND, 0, 0);
  endtask

  // Mostly acks, ticks and passes against the current transfer; starts are
  // sized to fit, with an occasional raw size as noise.
  function automatic item_t pick_item();
    item_t it;
    int unsigned cap, roll;
    it.kind = KIND_TICK;
    it.msg_len = SIZE_W'($urandom);
    it.frag_id = ID_W'($urandom);
    roll = $urandom_range(99);
    if (roll < 8) begin
      it.kind = KIND_START;
      if ($urandom_range(9) != 0) begin
        cap = 32'(payload_cfg);
        cap = cap * FRAG_SLOTS;
        if (cap > BUFFER_BYTES) cap = BUFFER_BYTES;
        it.msg_len = SIZE_W'($urandom_range(0, cap));
      end
    end else if (roll < 50) begin
      it.kind = KIND_ACK;
      if (frag_count != 0 && $urandom_range(4) != 0)
        it.frag_id = ID_W'($urandom_range(0, frag_count - 1));
    end else if (roll >= 75) begin
      it.kind = KIND_SEND;
    end
    return it;
  endfunction

  task automatic test_random(input int unsigned idle_pct, input int unsigned stall,
                             input int unsigned n_items);
    logic [SIZE_W-1:0] mp;
    logic [TIME_W-1:0] to;
    int s, i;
    for (s = 0; s < 3; s++) begin
      wait_idle();
      send_idle_pct = idle_pct;
      stall_pct = stall;
      case ($urandom_range(3))
        0:       mp = SIZE_W'($urandom_range(1, 8));
        1:       mp = SIZE_W'($urandom_range(9, 128));
        2:       mp = SIZE_W'($urandom_range(129, 2048));
        default: mp = SIZE_W'($urandom_range(2049, 4095));
      endcase
      case ($urandom_range(4))
        0:       to = 0;
        1:       to = 1;
        2:       to = $urandom_range(2, 6);
        3:       to = $urandom_range(7, 40);
        default: to = $urandom;
      endcase
      set_config(mp, to);
      for (i = 0; i < n_items / 3; i++) send_item(pick_item());
    end
  endtask

  initial begin : run_tests
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_basic_transfer();
    test_payload_extremes();
    test_timeout_resend();
    test_backpressure();
    test_random(0, 0, 108);
    test_random(81, 0, 108);
    test_random(0, 81, 108);
    test_random(32, 32, 108);
    wait_idle();
    if (errors == 0) begin
      $display("fragment_retransmit_tracker_tb passed");
    end else begin
      $display("fragment_retransmit_tracker_tb failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/frt_pkg.sv
hw/rtl/frt_cfg.sv
hw/rtl/frt_size_mem.sv
hw/rtl/fragment_retransmit_tracker.sv
bench/fragment_retransmit_tracker_tb.sv
